>>> rtl/core/bm25f_pkg.sv
// bm25f_pkg: shared types, widths and codes of the bm25f document scorer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bm25f_pkg;

  // field widths
  localparam int ID_W    = 32;
  localparam int WT_W    = 32;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 24;
  localparam int SCORE_W = 48;
  localparam int K_W     = 20;
  localparam int B_W     = 17;
  localparam int W_W     = 21;
  localparam int AVG_W   = 40;
  localparam int TF_W    = 32;

  // shared divider geometry
  localparam int DIV_D_W   = 40;
  localparam int DIV_Q_W   = 38;
  localparam int DIV_CNT_W = 6;

  // register port geometry
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [K_W-1:0]   RST_K_SATURATION = 20'd78643;
  localparam logic [B_W-1:0]   RST_LEN_NORM     = 17'd49152;
  localparam logic [W_W-1:0]   RST_FIELD_WEIGHT = 21'd131072;
  localparam logic [AVG_W-1:0] RST_AVG_LENGTH   = 40'd65536;

  // register indexes
  typedef enum logic [2:0] {
    REG_K_SATURATION     = 3'd0,
    REG_FIELD_LEN_NORM   = 3'd1,
    REG_BODY_LEN_NORM    = 3'd2,
    REG_FIELD_WEIGHT     = 3'd3,
    REG_AVG_FIELD_LENGTH = 3'd4,
    REG_AVG_BODY_LENGTH  = 3'd5
  } reg_idx_e;

  // which counts of an item are nonzero
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_BODY  = 2'd2,
    KIND_BOTH  = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    DIV_IDLE  = 2'd0,
    DIV_CHECK = 2'd1,
    DIV_RUN   = 2'd2
  } div_state_e;

  typedef enum logic [3:0] {
    BK_IDLE         = 4'd0,
    BK_RATIO        = 4'd1,
    BK_RATIO_WAIT   = 4'd2,
    BK_DENOM_MUL    = 4'd3,
    BK_TF_START     = 4'd4,
    BK_TF_WAIT      = 4'd5,
    BK_COMB_MUL     = 4'd6,
    BK_COMBINE      = 4'd7,
    BK_FACTOR_MUL   = 4'd8,
    BK_FACTOR_START = 4'd9,
    BK_FACTOR_WAIT  = 4'd10,
    BK_TERM_MUL     = 4'd11,
    BK_ACCUM        = 4'd12,
    BK_EMIT         = 4'd13
  } back_state_e;

  typedef struct packed {
    logic [ID_W-1:0]  doc_id;
    logic [WT_W-1:0]  term_weight;
    logic [CNT_W-1:0] field_count;
    logic [CNT_W-1:0] body_count;
    logic [LEN_W-1:0] field_length;
    logic [LEN_W-1:0] body_length;
    logic             last_term;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    doc_out;
    logic [SCORE_W-1:0] doc_score;
  } out_item_t;

  typedef struct packed {
    logic [K_W-1:0]   k_saturation;
    logic [B_W-1:0]   field_len_norm;
    logic [B_W-1:0]   body_len_norm;
    logic [W_W-1:0]   field_weight;
    logic [AVG_W-1:0] avg_field_length;
    logic [AVG_W-1:0] avg_body_length;
  } cfg_t;

  // item after the front has classified it
  typedef struct packed {
    logic [ID_W-1:0]  doc_id;
    logic [WT_W-1:0]  term_weight;
    logic [CNT_W-1:0] field_count;
    logic [CNT_W-1:0] body_count;
    logic [LEN_W-1:0] field_length;
    logic [LEN_W-1:0] body_length;
    logic             last_term;
    item_kind_e       kind;
  } cls_item_t;

  // divider request: remainder start, low dividend bits left aligned
  typedef struct packed {
    logic                 start;
    logic [DIV_D_W-1:0]   rem;
    logic [DIV_Q_W-1:0]   low;
    logic [DIV_D_W-1:0]   den;
    logic [DIV_CNT_W-1:0] bits;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/bm25f_div.sv
// bm25f_div: shared radix-2 restoring divider, one quotient bit per cycle
// depends on bm25f_pkg; flags overflow when the quotient exceeds the requested bits
`timescale 1ns / 1ps
`default_nettype none

module bm25f_div
  import bm25f_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  div_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 ovf_q, ovf_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_D_W-1:0]   den_q, den_d;
  logic [DIV_Q_W-1:0]   low_q, low_d;
  logic [DIV_Q_W-1:0]   quo_q, quo_d;

  logic [DIV_D_W:0] trial;
  logic [DIV_D_W:0] diff;
  logic             fits;

  // one restoring step
  assign trial = {rem_q, low_q[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  // next state and datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    rem_d   = rem_q;
    den_d   = den_q;
    low_d   = low_q;
    quo_d   = quo_q;
    case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          rem_d   = req_i.rem;
          den_d   = req_i.den;
          low_d   = req_i.low;
          quo_d   = '0;
          cnt_d   = req_i.bits;
          ovf_d   = 1'b0;
          state_d = DIV_CHECK;
        end
      end
      DIV_CHECK: begin
        // quotient would not fit in the requested bits
        if (rem_q >= den_q) begin
          ovf_d   = 1'b1;
          quo_d   = '1;
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        low_d = low_q << 1;
        quo_d = {quo_q[DIV_Q_W-2:0], fits};
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/bm25f_front.sv
// bm25f_front: input stage, masks lengths and classifies items by nonzero counts
// depends on bm25f_pkg; feeds bm25f_queue
`timescale 1ns / 1ps
`default_nettype none

module bm25f_front
  import bm25f_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      push_o,
  output cls_item_t push_item_o,
  input  logic      full_i
);

  localparam int LEN_KEEP = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
  localparam logic [LEN_W-1:0] LEN_MASK = {LEN_W{1'b1}} >> (LEN_W - LEN_KEEP);

  logic      hold_valid_q, hold_valid_d;
  cls_item_t hold_q;
  cls_item_t cls;
  logic      accept;

  // classify the incoming item
  always_comb begin
    cls.doc_id       = in_data_i.doc_id;
    cls.term_weight  = in_data_i.term_weight;
    cls.field_count  = in_data_i.field_count;
    cls.body_count   = in_data_i.body_count;
    cls.field_length = in_data_i.field_length & LEN_MASK;
    cls.body_length  = in_data_i.body_length & LEN_MASK;
    cls.last_term    = in_data_i.last_term;
    if ((in_data_i.field_count != '0) && (in_data_i.body_count != '0)) begin
      cls.kind = KIND_BOTH;
    end else if (in_data_i.field_count != '0) begin
      cls.kind = KIND_FIELD;
    end else if (in_data_i.body_count != '0) begin
      cls.kind = KIND_BODY;
    end else begin
      cls.kind = KIND_NONE;
    end
  end

  // handshake with the source and the queue
  assign in_stall_o  = hold_valid_q && full_i;
  assign push_o      = hold_valid_q && !full_i;
  assign push_item_o = hold_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= cls;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bm25f_queue.sv
// bm25f_queue: short queue of classified items between front and back
// depends on bm25f_pkg
`timescale 1ns / 1ps
`default_nettype none

module bm25f_queue
  import bm25f_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cls_item_t item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cls_item_t        entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bm25f_back.sv
// bm25f_back: scoring sequencer with one shared multiplier, accumulator and
// output register; depends on bm25f_pkg and bm25f_div
`timescale 1ns / 1ps
`default_nettype none

module bm25f_back
  import bm25f_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  cls_item_t q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int BC_W     = FRAC_BITS + 1;
  localparam int FACT_W   = FRAC_BITS + 4;
  localparam int MA_W     = FRAC_BITS + 5;
  localparam int MB_W     = DIV_Q_W;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int W_RATIO  = LEN_W + 2 * FRAC_BITS;
  localparam int W_FACT   = TF_W + FACT_W;
  localparam int WIDE_W   = (W_RATIO > W_FACT) ? W_RATIO : W_FACT;
  localparam int RATIO_QB = DIV_Q_W;
  localparam int TF_QB    = TF_W;
  localparam int FACT_QB  = FACT_W;
  localparam int TFS_W    = TF_W + 6;
  localparam int ACC_W    = SCORE_W + 1;
  localparam int DIVS_W   = TF_W + 1;

  localparam logic [31:0] ONE_Q  = 32'd1 << FRAC_BITS;
  localparam logic [31:0] K1_MAX = 32'd10 << FRAC_BITS;
  localparam logic [31:0] W_MAX  = 32'd16 << FRAC_BITS;

  back_state_e         state_q, state_d;
  cls_item_t           item_q, item_d;
  logic                side_body_q, side_body_d;
  logic [DIV_Q_W-1:0]  ratio_q, ratio_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [TF_W-1:0]     tf_field_q, tf_field_d;
  logic [TF_W-1:0]     tf_body_q, tf_body_d;
  logic [TF_W-1:0]     tf_q, tf_d;
  logic [DIVS_W-1:0]   div_q, div_d;
  logic [FACT_W-1:0]   factor_q, factor_d;
  logic [SCORE_W-1:0]  sum_q, sum_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CNT_W-1:0]   cnt_s;
  logic [LEN_W-1:0]   len_s;
  logic [AVG_W-1:0]   avg_s, avg_nz;
  logic [B_W-1:0]     b_s;
  logic [BC_W-1:0]    b_c;
  logic [MA_W-1:0]    w_c;
  logic [FACT_W-1:0]  k1_c, k1_one;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [WIDE_W-1:0]  n_w;
  logic [DIV_D_W-1:0] denom;
  logic [TF_W-1:0]    tf_div;
  logic [TFS_W-1:0]   tf_sum;
  logic [ACC_W-1:0]   acc;
  logic               out_free;

  bm25f_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // operands of the side being worked on
  always_comb begin
    cnt_s  = side_body_q ? item_q.body_count : item_q.field_count;
    len_s  = side_body_q ? item_q.body_length : item_q.field_length;
    avg_s  = side_body_q ? cfg_i.avg_body_length : cfg_i.avg_field_length;
    b_s    = side_body_q ? cfg_i.body_len_norm : cfg_i.field_len_norm;
    avg_nz = (avg_s == '0) ? AVG_W'(1) : avg_s;
  end

  // clamped configuration values
  always_comb begin
    b_c    = (32'(b_s) > ONE_Q) ? BC_W'(ONE_Q) : BC_W'(b_s);
    w_c    = (32'(cfg_i.field_weight) > W_MAX) ? MA_W'(W_MAX) : MA_W'(cfg_i.field_weight);
    k1_c   = (32'(cfg_i.k_saturation) > K1_MAX) ? FACT_W'(K1_MAX)
                                                 : FACT_W'(cfg_i.k_saturation);
    k1_one = k1_c + FACT_W'(ONE_Q);
  end

  // length normalization denominator and divider results
  assign denom  = DIV_D_W'(ONE_Q) - DIV_D_W'(b_c) + DIV_D_W'(prod_q >> FRAC_BITS);
  assign tf_div = div_rsp.ovf ? '1 : div_rsp.quo[TF_W-1:0];
  assign tf_sum = TFS_W'(prod_q >> FRAC_BITS) + TFS_W'(tf_body_q);
  assign acc    = ACC_W'(sum_q) + ACC_W'(prod_q >> FRAC_BITS);
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer: next state, multiplier operands and divider requests
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    side_body_d = side_body_q;
    ratio_d     = ratio_q;
    prod_d      = prod_q;
    tf_field_d  = tf_field_q;
    tf_body_d   = tf_body_q;
    tf_d        = tf_q;
    div_d       = div_q;
    factor_d    = factor_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    n_w         = '0;
    div_req     = '0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          item_d     = q_item_i;
          tf_field_d = '0;
          tf_body_d  = '0;
          case (q_item_i.kind)
            KIND_NONE: begin
              state_d = BK_EMIT;
            end
            KIND_BODY: begin
              side_body_d = 1'b1;
              state_d     = BK_RATIO;
            end
            default: begin
              side_body_d = 1'b0;
              state_d     = BK_RATIO;
            end
          endcase
        end
      end
      // length over average, Q.F
      BK_RATIO: begin
        n_w           = WIDE_W'(len_s) << (2 * FRAC_BITS);
        div_req.start = 1'b1;
        div_req.rem   = DIV_D_W'(n_w >> RATIO_QB);
        div_req.low   = DIV_Q_W'(n_w);
        div_req.den   = avg_nz;
        div_req.bits  = DIV_CNT_W'(RATIO_QB);
        state_d       = BK_RATIO_WAIT;
      end
      BK_RATIO_WAIT: begin
        if (div_rsp.done) begin
          ratio_d = div_rsp.ovf ? '1 : div_rsp.quo;
          state_d = BK_DENOM_MUL;
        end
      end
      BK_DENOM_MUL: begin
        mul_a   = MA_W'(b_c);
        mul_b   = ratio_q;
        prod_d  = mul_p;
        state_d = BK_TF_START;
      end
      // count over normalized length; a zero denominator overflows to the cap
      BK_TF_START: begin
        n_w           = WIDE_W'(cnt_s) << (2 * FRAC_BITS);
        div_req.start = 1'b1;
        div_req.rem   = DIV_D_W'(n_w >> TF_QB);
        div_req.low   = DIV_Q_W'(n_w << (DIV_Q_W - TF_QB));
        div_req.den   = denom;
        div_req.bits  = DIV_CNT_W'(TF_QB);
        state_d       = BK_TF_WAIT;
      end
      BK_TF_WAIT: begin
        if (div_rsp.done) begin
          if (side_body_q) begin
            tf_body_d = tf_div;
            state_d   = BK_COMB_MUL;
          end else begin
            tf_field_d = tf_div;
            if (item_q.kind == KIND_BOTH) begin
              side_body_d = 1'b1;
              state_d     = BK_RATIO;
            end else begin
              state_d = BK_COMB_MUL;
            end
          end
        end
      end
      BK_COMB_MUL: begin
        mul_a   = w_c;
        mul_b   = MB_W'(tf_field_q);
        prod_d  = mul_p;
        state_d = BK_COMBINE;
      end
      // weighted field tf plus body tf, capped
      BK_COMBINE: begin
        tf_d    = (|tf_sum[TFS_W-1:TF_W]) ? '1 : tf_sum[TF_W-1:0];
        state_d = BK_FACTOR_MUL;
      end
      BK_FACTOR_MUL: begin
        mul_a   = MA_W'(k1_one);
        mul_b   = MB_W'(tf_q);
        prod_d  = mul_p;
        div_d   = DIVS_W'(k1_c) + DIVS_W'(tf_q);
        state_d = BK_FACTOR_START;
      end
      // saturation factor (k1 + 1) * tf / (k1 + tf)
      BK_FACTOR_START: begin
        if (div_q == '0) begin
          state_d = BK_EMIT;
        end else begin
          n_w           = WIDE_W'(prod_q);
          div_req.start = 1'b1;
          div_req.rem   = DIV_D_W'(n_w >> FACT_QB);
          div_req.low   = DIV_Q_W'(n_w << (DIV_Q_W - FACT_QB));
          div_req.den   = DIV_D_W'(div_q);
          div_req.bits  = DIV_CNT_W'(FACT_QB);
          state_d       = BK_FACTOR_WAIT;
        end
      end
      BK_FACTOR_WAIT: begin
        if (div_rsp.done) begin
          factor_d = div_rsp.quo[FACT_W-1:0];
          state_d  = BK_TERM_MUL;
        end
      end
      BK_TERM_MUL: begin
        mul_a   = MA_W'(factor_q);
        mul_b   = MB_W'(item_q.term_weight);
        prod_d  = mul_p;
        state_d = BK_ACCUM;
      end
      // saturating accumulate
      BK_ACCUM: begin
        sum_d   = acc[SCORE_W] ? '1 : acc[SCORE_W-1:0];
        state_d = BK_EMIT;
      end
      // document end: transfer a nonzero score once the output is free
      BK_EMIT: begin
        if (!item_q.last_term || (sum_q == '0)) begin
          state_d = BK_IDLE;
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_data_d.doc_out   = item_q.doc_id;
          out_data_d.doc_score = sum_q;
          sum_d                = '0;
          state_d              = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control state and score accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      side_body_q <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_body_q <= side_body_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ratio_q    <= ratio_d;
    prod_q     <= prod_d;
    tf_field_q <= tf_field_d;
    tf_body_q  <= tf_body_d;
    tf_q       <= tf_d;
    div_q      <= div_d;
    factor_q   <= factor_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/bm25f_document_scorer.sv
// BM25F two-field document scorer.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per
// (document, query term). An item carrying last_term closes the document.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transfer per
// closed document whose accumulated score is nonzero; zero scores are dropped.
// Register port: APB-style, 64-bit data, register i at byte address 8*i;
// write the registers only while the block is idle.
// Operation: the back end handles one item at a time, using one radix-2 divider
// that produces one quotient bit per cycle. Per side with a nonzero count it
// runs a 38-bit and a 32-bit division and one multiply step, then per item a
// FRAC_BITS+4 bit division and three more multiply steps. An item with both
// counts zero skips the divisions. An item passes through an input register,
// the queue, the back end and an output register on its way to the result.
// A two-entry queue lets up to three items wait.
// Reset clears the score accumulator, the queue and the output valid flag and
// loads the register defaults. While out_stall_i is high the finished result
// is held and the back end waits at the next document end; input items keep
// flowing into the queue until it fills, then in_stall_o rises.
// depends on bm25f_pkg, bm25f_front, bm25f_queue, bm25f_back
`timescale 1ns / 1ps
`default_nettype none

module bm25f_document_scorer
  import bm25f_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg_q, cfg_d;
  reg_idx_e  reg_idx;
  logic      cfg_write;
  logic      push;
  cls_item_t push_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  cls_item_t q_item;

  // register port decode
  assign reg_idx   = reg_idx_e'(paddr[APB_AW-1:3]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_idx)
        REG_K_SATURATION:     cfg_d.k_saturation     = pwdata[K_W-1:0];
        REG_FIELD_LEN_NORM:   cfg_d.field_len_norm   = pwdata[B_W-1:0];
        REG_BODY_LEN_NORM:    cfg_d.body_len_norm    = pwdata[B_W-1:0];
        REG_FIELD_WEIGHT:     cfg_d.field_weight     = pwdata[W_W-1:0];
        REG_AVG_FIELD_LENGTH: cfg_d.avg_field_length = pwdata[AVG_W-1:0];
        REG_AVG_BODY_LENGTH:  cfg_d.avg_body_length  = pwdata[AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_K_SATURATION:     prdata = APB_DW'(cfg_q.k_saturation);
      REG_FIELD_LEN_NORM:   prdata = APB_DW'(cfg_q.field_len_norm);
      REG_BODY_LEN_NORM:    prdata = APB_DW'(cfg_q.body_len_norm);
      REG_FIELD_WEIGHT:     prdata = APB_DW'(cfg_q.field_weight);
      REG_AVG_FIELD_LENGTH: prdata = APB_DW'(cfg_q.avg_field_length);
      REG_AVG_BODY_LENGTH:  prdata = APB_DW'(cfg_q.avg_body_length);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_saturation     <= RST_K_SATURATION;
      cfg_q.field_len_norm   <= RST_LEN_NORM;
      cfg_q.body_len_norm    <= RST_LEN_NORM;
      cfg_q.field_weight     <= RST_FIELD_WEIGHT;
      cfg_q.avg_field_length <= RST_AVG_LENGTH;
      cfg_q.avg_body_length  <= RST_AVG_LENGTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input stage and classification
  bm25f_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (q_full)
  );

  // decoupling queue
  bm25f_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  // scoring back end
  bm25f_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> verif/bm25f_document_scorer_test.sv
// bm25f_document_scorer_test: self-checking bench for the bm25f document scorer
// holds a fixed-point score predictor, random term traffic and register setups
// depends on bm25f_pkg and bm25f_document_scorer
`timescale 1ns / 1ps

module bm25f_document_scorer_test;
  import bm25f_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] ONE_Q     = 64'd1 << FRAC;
  localparam logic [63:0] K1_MAX    = 64'd10 << FRAC;
  localparam logic [63:0] W_MAX     = 64'd16 << FRAC;
  localparam logic [63:0] RATIO_CAP = (64'd1 << 38) - 64'd1;
  localparam logic [63:0] TF_CAP    = (64'd1 << 32) - 64'd1;
  localparam logic [63:0] SUM_MAX   = (64'd1 << 48) - 64'd1;
  // worst case: three queued items plus one in the back end
  localparam int DRAIN_CYCLES = 1000;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state: register copy and running document sum
  cfg_t        scorer_cfg;
  logic [63:0] doc_sum;
  out_item_t   pending_scores[$];
  out_item_t   oldest_score;

  int          items_sent = 0;
  int          scores_checked = 0;
  int          mismatches = 0;
  int          settings_used = 0;
  int          send_gap_pct = 20;
  int          sink_stall_pct = 20;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;

  bm25f_document_scorer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // score predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] limit_to(input logic [63:0] v, input logic [63:0] hi);
    return (v > hi) ? hi : v;
  endfunction

  // (num << FRAC) / den in two steps, all ones when the quotient overflows
  function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = num / den;
    r = num % den;
    if ((q >> (64 - FRAC)) != 0) return '1;
    return (q << FRAC) + ((r << FRAC) / den);
  endfunction

  // count / (1 - b + b * len / avg), capped
  function automatic logic [63:0] norm_tf(input logic [63:0] count, input logic [63:0] len,
                                          input logic [63:0] avg, input logic [63:0] b);
    logic [63:0] avg_nz;
    logic [63:0] ratio;
    logic [63:0] b_cl;
    logic [63:0] denom;
    if (count == 0) return 64'd0;
    avg_nz = (avg == 0) ? 64'd1 : avg;
    ratio = limit_to(frac_div(len << FRAC, avg_nz), RATIO_CAP);
    b_cl = limit_to(b, ONE_Q);
    denom = ONE_Q - b_cl + ((b_cl * ratio) >> FRAC);
    if (denom == 0) return TF_CAP;
    return limit_to(frac_div(count << FRAC, denom), TF_CAP);
  endfunction

  // fold one term into the document sum, queue the score on a document end
  task automatic accumulate_term(input in_item_t item);
    logic [63:0] tf_f;
    logic [63:0] tf_b;
    logic [63:0] w;
    logic [63:0] k1;
    logic [63:0] tf;
    logic [63:0] divisor;
    logic [63:0] factor;
    logic [63:0] term;
    out_item_t   score;
    if (item.field_count != 0 || item.body_count != 0) begin
      tf_f = norm_tf(64'(item.field_count), 64'(item.field_length),
                     64'(scorer_cfg.avg_field_length), 64'(scorer_cfg.field_len_norm));
      tf_b = norm_tf(64'(item.body_count), 64'(item.body_length),
                     64'(scorer_cfg.avg_body_length), 64'(scorer_cfg.body_len_norm));
      w = limit_to(64'(scorer_cfg.field_weight), W_MAX);
      k1 = limit_to(64'(scorer_cfg.k_saturation), K1_MAX);
      tf = limit_to(((w * tf_f) >> FRAC) + tf_b, TF_CAP);
      divisor = k1 + tf;
      if (divisor != 0) begin
        factor = ((k1 + ONE_Q) * tf) / divisor;
        term = (64'(item.term_weight) * factor) >> FRAC;
        doc_sum = limit_to(doc_sum + limit_to(term, SUM_MAX), SUM_MAX);
      end
    end
    if (item.last_term) begin
      if (doc_sum != 0) begin
        score.doc_out = item.doc_id;
        score.doc_score = doc_sum[SCORE_W-1:0];
        pending_scores.push_back(score);
      end
      doc_sum = 64'd0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one term transfer; valid stays high afterwards unless a gap follows
  task automatic send_term(input in_item_t item);
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_term(item);
    items_sent++;
  endtask

  // stop sending, wait for every score, then let the back end go idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_K_SATURATION:     scorer_cfg.k_saturation = value[K_W-1:0];
      REG_FIELD_LEN_NORM:   scorer_cfg.field_len_norm = value[B_W-1:0];
      REG_BODY_LEN_NORM:    scorer_cfg.body_len_norm = value[B_W-1:0];
      REG_FIELD_WEIGHT:     scorer_cfg.field_weight = value[W_W-1:0];
      REG_AVG_FIELD_LENGTH: scorer_cfg.avg_field_length = value[AVG_W-1:0];
      REG_AVG_BODY_LENGTH:  scorer_cfg.avg_body_length = value[AVG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for idle, then program all six registers
  task automatic load_settings(input logic [K_W-1:0] k, input logic [B_W-1:0] b1,
                               input logic [B_W-1:0] b2, input logic [W_W-1:0] w,
                               input logic [AVG_W-1:0] avg_f, input logic [AVG_W-1:0] avg_b);
    drain_results();
    write_register(REG_K_SATURATION, 64'(k));
    write_register(REG_FIELD_LEN_NORM, 64'(b1));
    write_register(REG_BODY_LEN_NORM, 64'(b2));
    write_register(REG_FIELD_WEIGHT, 64'(w));
    write_register(REG_AVG_FIELD_LENGTH, 64'(avg_f));
    write_register(REG_AVG_BODY_LENGTH, 64'(avg_b));
    settings_used++;
  endtask

  function automatic in_item_t term_item(input logic [ID_W-1:0] doc, input logic [WT_W-1:0] wt,
                                         input logic [CNT_W-1:0] fc, input logic [CNT_W-1:0] bc,
                                         input logic [LEN_W-1:0] fl, input logic [LEN_W-1:0] bl,
                                         input logic last);
    in_item_t t;
    t.doc_id = doc;
    t.term_weight = wt;
    t.field_count = fc;
    t.body_count = bc;
    t.field_length = fl;
    t.body_length = bl;
    t.last_term = last;
    return t;
  endfunction

  function automatic logic [31:0] pick_edge(input logic [31:0] max_val);
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return 32'd1;
      default: return max_val;
    endcase
  endfunction

  // mostly realistic terms, some full-range and some at the field limits
  function automatic in_item_t random_term(input logic [ID_W-1:0] doc, input logic last);
    int shape;
    shape = int'($urandom_range(0, 99));
    if (shape < 70) begin
      return term_item(doc, WT_W'($urandom_range(0, 8 << FRAC)),
                       CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 30)),
                       LEN_W'($urandom_range(0, 40)), LEN_W'($urandom_range(0, 600)), last);
    end else if (shape < 85) begin
      return term_item(doc, WT_W'($urandom()), CNT_W'($urandom_range(0, 16'hFFFF)),
                       CNT_W'($urandom_range(0, 16'hFFFF)),
                       LEN_W'($urandom_range(0, 24'hFFFFFF)),
                       LEN_W'($urandom_range(0, 24'hFFFFFF)), last);
    end
    return term_item(doc, pick_edge(32'hFFFFFFFF), CNT_W'(pick_edge(32'hFFFF)),
                     CNT_W'(pick_edge(32'hFFFF)), LEN_W'(pick_edge(32'hFFFFFF)),
                     LEN_W'(pick_edge(32'hFFFFFF)), last);
  endfunction

  // a document of 1 to 8 terms; a few lack the closing mark or close early
  task automatic send_random_document();
    logic [ID_W-1:0] doc;
    int              n_terms;
    bit              closed;
    logic            last;
    doc = $urandom();
    n_terms = $urandom_range(1, 8);
    closed = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < n_terms; i++) begin
      last = (i == n_terms - 1) ? closed : ($urandom_range(0, 19) == 0);
      send_term(random_term(doc, last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 99) >= sink_stall_pct) begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 99) < 3) repeat ($urandom_range(30, 150)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        flag_mismatch("unexpected score for doc", 64'd0, 64'(out_data.doc_out));
      end else begin
        oldest_score = pending_scores.pop_front();
        if (out_data.doc_out !== oldest_score.doc_out)
          flag_mismatch("doc_out", 64'(oldest_score.doc_out), 64'(out_data.doc_out));
        if (out_data.doc_score !== oldest_score.doc_score)
          flag_mismatch("doc_score", 64'(oldest_score.doc_score), 64'(out_data.doc_score));
        scores_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: typical, empty, full-range and one-sided terms
  task automatic test_default_registers();
    send_term(term_item(32'd1, 32'd98304, 16'd2, 16'd5, 24'd4, 24'd120, 1'b1));
    send_term(term_item(32'd2, 32'd65536, 16'd0, 16'd0, 24'd9, 24'd9, 1'b1));
    send_term(term_item('1, '1, '1, '1, '1, '1, 1'b1));
    send_term(term_item(32'd4, 32'd70000, 16'd1, 16'd0, 24'd3, 24'd50, 1'b0));
    send_term(term_item(32'd4, 32'd30000, 16'd0, 16'd3, 24'd3, 24'd50, 1'b0));
    send_term(term_item(32'd4, 32'd123456, 16'd7, 16'd11, 24'd3, 24'd50, 1'b1));
    send_term(term_item(32'd5, 32'd0, 16'd4, 16'd4, 24'd2, 24'd2, 1'b1));
    send_term(term_item(32'd6, 32'd65536, 16'd1, 16'd1, 24'd0, 24'd0, 1'b1));
    send_term(term_item(32'd0, 32'd0, 16'd0, 16'd0, 24'd0, 24'd0, 1'b0));
    send_term(term_item(32'd0, 32'hFFFFFFFF, 16'd1, 16'd0, 24'd1, 24'd0, 1'b1));
  endtask

  // zero averages, zero normalization denominators, zero saturation divisor
  task automatic test_corner_registers();
    load_settings(RST_K_SATURATION, 17'd65536, 17'd65536, RST_FIELD_WEIGHT, 40'd0, 40'd0);
    send_term(term_item(32'd10, 32'd65536, 16'd3, 16'd0, 24'd0, 24'd0, 1'b1));
    send_term(term_item(32'd11, 32'd65536, 16'd0, 16'd2, 24'd0, 24'd7, 1'b1));
    send_term(term_item(32'd12, 32'd200000, 16'd1, 16'd1, 24'd1, 24'd2, 1'b1));
    load_settings(20'd0, RST_LEN_NORM, 17'd65536, 21'd0, RST_AVG_LENGTH, 40'd1);
    send_term(term_item(32'd13, '1, 16'd5, 16'd1, 24'd3, '1, 1'b1));
    send_term(term_item(32'd14, '1, 16'd0, 16'd1, 24'd0, '1, 1'b0));
    send_term(term_item(32'd14, '1, 16'd0, 16'd0, 24'd0, 24'd0, 1'b1));
    send_term(term_item(32'd15, 32'd65536, 16'd0, 16'd1, 24'd0, 24'd0, 1'b1));
  endtask

  // random documents under several register settings and idling mixes
  task automatic test_random_documents();
    int start;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_settings(20'd78643, 17'd49152, 17'd49152, 21'd131072,
                         40'd10 << FRAC, 40'd200 << FRAC);
        1: load_settings(20'd0, 17'd0, 17'd0, 21'd0, 40'd1, 40'd1);
        2: load_settings(20'd655360, 17'd65536, 17'd65536, 21'd1048576, '1, '1);
        3: load_settings('1, '1, '1, '1, 40'd3 << FRAC, {$urandom(), 8'($urandom())});
        default: load_settings(K_W'($urandom()), B_W'($urandom()), B_W'($urandom()),
                               W_W'($urandom()), {$urandom(), 8'($urandom())},
                               {$urandom(), 8'($urandom())});
      endcase
      case (phase)
        0: begin send_gap_pct = 30; sink_stall_pct = 30; end
        1: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        2: begin send_gap_pct = 60; sink_stall_pct = 50; end
        3: begin send_gap_pct = 15; sink_stall_pct = 15; end
        default: begin send_gap_pct = 40; sink_stall_pct = 70; end
      endcase
      start = items_sent;
      while (items_sent - start < 200) begin
        send_random_document();
        // hold off at least once per phase, near 100 terms, until every score is back
        if (items_sent - start >= 100 && items_sent - start < 108) drain_results();
      end
    end
  endtask

  // one long document of maximal terms builds a large running sum
  task automatic test_long_document();
    logic [ID_W-1:0] doc;
    load_settings(20'd655360, 17'd65536, RST_LEN_NORM, 21'd1048576, RST_AVG_LENGTH,
                  RST_AVG_LENGTH);
    quiet = 1'b1;
    doc = $urandom();
    for (int n = 0; n < 48; n++)
      send_term(term_item(doc, '1, 16'd1, 16'd0, 24'd0, 24'd0, 1'b0));
    send_term(term_item(doc, '1, 16'd1, 16'd0, 24'd0, 24'd0, 1'b1));
  endtask

  initial begin
    scorer_cfg.k_saturation = RST_K_SATURATION;
    scorer_cfg.field_len_norm = RST_LEN_NORM;
    scorer_cfg.body_len_norm = RST_LEN_NORM;
    scorer_cfg.field_weight = RST_FIELD_WEIGHT;
    scorer_cfg.avg_field_length = RST_AVG_LENGTH;
    scorer_cfg.avg_body_length = RST_AVG_LENGTH;
    doc_sum = 64'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_registers();
    test_corner_registers();
    test_random_documents();
    test_long_document();

    drain_results();
    if (pending_scores.size() != 0)
      flag_mismatch("scores never delivered", 64'(pending_scores.size()), 64'd0);
    $display("sent %0d term transfers under %0d register setups, checked %0d doc scores",
             items_sent, settings_used, scores_checked);
    $display("covered field extremes, zero averages and denominators, long maximal documents");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
